@@ rtl/core/hse_pkg.sv @@
// hse_pkg: constants and beat types shared by the heap sort engine
// no dependencies; used by hse_ctrl and heap_sort_engine

package hse_pkg;

   // store capacity and derived widths
   localparam int MAX_ELEMENTS = 64;
   localparam int DATA_W       = 32;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

   // input beat
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_beat_type;

   // result beat
   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     final_res;
      logic                     overflow;
   } rsp_beat_type;

   // element store access from the controller
   typedef struct packed {
      logic                     wr_en;
      logic [ADDR_W-1:0]        wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic                     rd_en;
      logic [ADDR_W-1:0]        rd_addr;
   } ram_cmd_type;

endpackage

@@ rtl/core/hse_ram.sv @@
// hse_ram: generic one-write, one-read synchronous memory
// registered read data, held while rd_en is low; no dependencies

module hse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/hse_ctrl.sv @@
// hse_ctrl: load, heap build, extraction and readout sequencer
// depends on hse_pkg; drives the element store through a ram_cmd_type bundle

module hse_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hse_pkg::req_beat_type            req_beat,
   output hse_pkg::ram_cmd_type             ram_cmd,
   input  logic signed [hse_pkg::DATA_W-1:0] ram_rd_data,
   output logic                             push_valid,
   output hse_pkg::rsp_beat_type            push_beat,
   input  logic                             out_free
);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SIFT_INIT,
      ST_SIFT_GET,
      ST_SIFT_LC,
      ST_SIFT_RC,
      ST_SIFT_CMP,
      ST_SIFT_END,
      ST_EXT_RD0,
      ST_EXT_RDK,
      ST_EXT_SWAP,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

   state_type                         state_ff, state_in;
   logic [hse_pkg::CNT_W-1:0]         count_ff, count_in;
   logic                              drop_ff, drop_in;
   logic [hse_pkg::CNT_W-1:0]         size_ff, size_in;
   logic [hse_pkg::ADDR_W-1:0]        start_ff, start_in;
   logic [hse_pkg::ADDR_W-1:0]        node_ff, node_in;
   logic [hse_pkg::ADDR_W-1:0]        idx_ff, idx_in;
   logic                              build_ff, build_in;
   logic signed [hse_pkg::DATA_W-1:0] sv_ff, sv_in;
   logic signed [hse_pkg::DATA_W-1:0] tmp_ff, tmp_in;

   logic                              accept;
   logic [hse_pkg::CNT_W-1:0]         cnt_new;
   logic [hse_pkg::ADDR_W+1:0]        lc_x, rc_x, size_x;
   logic                              lc_ok, rc_ok;
   logic                              lc_gt, rc_gt;
   logic signed [hse_pkg::DATA_W-1:0] big1_val, big_val;
   logic [hse_pkg::ADDR_W-1:0]        big1_idx, big_idx;
   logic [hse_pkg::CNT_W-1:0]         idx_p1;

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && (state_ff == ST_LOAD);

   // child indexes of the current node and their range checks
   assign lc_x   = {1'b0, node_ff, 1'b1};
   assign rc_x   = lc_x + (hse_pkg::ADDR_W+2)'(1);
   assign size_x = (hse_pkg::ADDR_W+2)'(size_ff);
   assign lc_ok  = (lc_x < size_x);
   assign rc_ok  = (rc_x < size_x);

   // pick the largest of node, left child (tmp_ff) and right child (read data)
   assign lc_gt    = (tmp_ff > sv_ff);
   assign big1_val = lc_gt ? tmp_ff : sv_ff;
   assign big1_idx = lc_gt ? lc_x[hse_pkg::ADDR_W-1:0] : node_ff;
   assign rc_gt    = rc_ok && (ram_rd_data > big1_val);
   assign big_val  = rc_gt ? ram_rd_data : big1_val;
   assign big_idx  = rc_gt ? rc_x[hse_pkg::ADDR_W-1:0] : big1_idx;

   // readout beat
   assign idx_p1                 = hse_pkg::CNT_W'(idx_ff) + hse_pkg::CNT_W'(1);
   assign push_beat.sorted_value = ram_rd_data;
   assign push_beat.final_res    = (idx_p1 == count_ff);
   assign push_beat.overflow     = drop_ff;

   // next state and store accesses
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      drop_in    = drop_ff;
      size_in    = size_ff;
      start_in   = start_ff;
      node_in    = node_ff;
      idx_in     = idx_ff;
      build_in   = build_ff;
      sv_in      = sv_ff;
      tmp_in     = tmp_ff;
      cnt_new    = count_ff;
      push_valid = 1'b0;
      ram_cmd    = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               // append while there is room, otherwise note the drop
               if (count_ff < hse_pkg::CNT_W'(hse_pkg::MAX_ELEMENTS)) begin
                  ram_cmd.wr_en   = 1'b1;
                  ram_cmd.wr_addr = count_ff[hse_pkg::ADDR_W-1:0];
                  ram_cmd.wr_data = req_beat.value;
                  cnt_new         = count_ff + hse_pkg::CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               count_in = cnt_new;
               if (req_beat.last) begin
                  if (cnt_new < hse_pkg::CNT_W'(2)) begin
                     idx_in   = '0;
                     state_in = ST_EMIT_RD;
                  end else begin
                     size_in  = cnt_new;
                     start_in = hse_pkg::ADDR_W'((cnt_new - hse_pkg::CNT_W'(2)) >> 1);
                     build_in = 1'b1;
                     state_in = ST_SIFT_INIT;
                  end
               end
            end
         end
         ST_SIFT_INIT: begin
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = start_ff;
            node_in         = start_ff;
            state_in        = ST_SIFT_GET;
         end
         ST_SIFT_GET: begin
            sv_in    = ram_rd_data;
            state_in = ST_SIFT_LC;
         end
         ST_SIFT_LC: begin
            if (lc_ok) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = lc_x[hse_pkg::ADDR_W-1:0];
               state_in        = ST_SIFT_RC;
            end else begin
               state_in = ST_SIFT_END;
            end
         end
         ST_SIFT_RC: begin
            tmp_in = ram_rd_data;
            if (rc_ok) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = rc_x[hse_pkg::ADDR_W-1:0];
            end
            state_in = ST_SIFT_CMP;
         end
         ST_SIFT_CMP: begin
            // move the larger child up into the hole and descend
            if (lc_gt || rc_gt) begin
               ram_cmd.wr_en   = 1'b1;
               ram_cmd.wr_addr = node_ff;
               ram_cmd.wr_data = big_val;
               node_in         = big_idx;
               state_in        = ST_SIFT_LC;
            end else begin
               state_in = ST_SIFT_END;
            end
         end
         ST_SIFT_END: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = node_ff;
            ram_cmd.wr_data = sv_ff;
            if (build_ff) begin
               if (start_ff == '0) begin
                  build_in = 1'b0;
                  size_in  = count_ff - hse_pkg::CNT_W'(1);
                  state_in = ST_EXT_RD0;
               end else begin
                  start_in = start_ff - hse_pkg::ADDR_W'(1);
                  state_in = ST_SIFT_INIT;
               end
            end else if (size_ff == hse_pkg::CNT_W'(1)) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               size_in  = size_ff - hse_pkg::CNT_W'(1);
               state_in = ST_EXT_RD0;
            end
         end
         ST_EXT_RD0: begin
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = '0;
            state_in        = ST_EXT_RDK;
         end
         ST_EXT_RDK: begin
            tmp_in          = ram_rd_data;
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = size_ff[hse_pkg::ADDR_W-1:0];
            state_in        = ST_EXT_SWAP;
         end
         ST_EXT_SWAP: begin
            // root goes to the last unsorted slot, that slot's value sifts from the root
            sv_in           = ram_rd_data;
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = size_ff[hse_pkg::ADDR_W-1:0];
            ram_cmd.wr_data = tmp_ff;
            node_in         = '0;
            state_in        = ST_SIFT_LC;
         end
         ST_EMIT_RD: begin
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = idx_ff;
            state_in        = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (out_free) begin
               push_valid = 1'b1;
               if (idx_p1 == count_ff) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + hse_pkg::ADDR_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         build_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         build_ff <= build_in;
      end
      size_ff  <= size_in;
      start_ff <= start_in;
      node_ff  <= node_in;
      idx_ff   <= idx_in;
      sv_ff    <= sv_in;
      tmp_ff   <= tmp_in;
   end

endmodule

@@ rtl/core/heap_sort_engine.sv @@
// Heap sort engine. Values are loaded one beat per cycle into a 64-entry store
// while loading; beats past capacity are dropped and flagged on every result of
// that set. A beat marked last starts the sort: the store is built into a
// max-heap and then drained by root extraction, each sift level taking two
// child reads and then one compare and write on the single-port-read element
// memory. Results then leave one at a time, each read from the store and then
// pushed when the output register is free, in ascending order, the largest
// marked final. No new beat is taken from the end of loading until the last
// result of the set has been handed to the output register.
// depends on hse_pkg, hse_ram and hse_ctrl

module heap_sort_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hse_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hse_pkg::rsp_beat_type rsp_beat
);

   hse_pkg::ram_cmd_type              ram_cmd;
   logic signed [hse_pkg::DATA_W-1:0] ram_rd_data;
   logic                              push_valid;
   hse_pkg::rsp_beat_type             push_beat;
   logic                              out_free;
   logic                              rsp_valid_ff;
   hse_pkg::rsp_beat_type             rsp_beat_ff;

   // element store
   hse_ram #(
      .WIDTH (hse_pkg::DATA_W),
      .DEPTH (hse_pkg::MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer
   hse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_beat    (req_beat),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data),
      .push_valid  (push_valid),
      .push_beat   (push_beat),
      .out_free    (out_free)
   );

   // result register, refilled in the cycle its beat is taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (push_valid) begin
         rsp_beat_ff <= push_beat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule
